// File: rtl/bpa_pkg.sv
// Shared constants and codes for the bitmap page allocator.
`default_nettype none
package bpa_pkg;

    localparam int NUM_PAGES_DEF = 4096;
    localparam int WORD_BITS_DEF = 64;

    localparam int PAGE_W = 12;
    localparam int LEN_W  = 13;
    localparam int CFG_W  = 13;

    localparam int COUNTER_MAX = 8191;

    typedef enum logic
    {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic
    {
        CFG_BASE_PAGE = 1'b0,
        CFG_TOP_PAGE  = 1'b1
    } cfg_idx_t;

    typedef struct packed
    {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage
`default_nettype wire

// File: rtl/bpa_map.sv
// Used-page bitmap memory with a registered read and a set-all sweep after reset.
`default_nettype none
module bpa_map
    import bpa_pkg::*;
#(
    parameter int WORDS = NUM_PAGES_DEF / WORD_BITS_DEF,
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int AW    = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  ready
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [AW-1:0]    clr_addr_reg;
    logic             clr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            if (clr_addr_reg == AW'(WORDS - 1))
                clr_done_reg <= 1'b1;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_done_reg)
            mem[clr_addr_reg] <= '1;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    assign ready = clr_done_reg;

endmodule
`default_nettype wire

// File: rtl/bpa_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bpa_div
    import bpa_pkg::*;
#(
    parameter int W = LEN_W
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output div_ctl_t          ctl,
    output logic      [W-1:0] quo
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                q_reg   <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[W-1:0];
                q_reg   <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quo       = q_reg;

endmodule
`default_nettype wire

// File: rtl/bitmap_page_allocator_top.sv
// Top level of the first-fit bitmap page allocator.
`default_nettype none
// One used bit per page lives in a word-wide memory (NUM_PAGES/WORD_BITS words,
// rounded up). After reset a sweep sets every word, one per cycle; no transaction
// is accepted until it ends. One transaction is in work at a time. Each bitmap word
// touched is read, then checked or written back. A free reads and writes back each
// word of its run. An allocation checks each candidate word by word; on a used page
// it jumps to the first aligned candidate past it through a divider and a multiply,
// and a fitting run costs a second pass that marks its words. WORD_BITS must be a
// power of two.
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [LEN_W-1:0]  run_length,
    input  wire logic [LEN_W-1:0]  align_step,
    input  wire logic [LEN_W-1:0]  upper_page,
    input  wire logic [PAGE_W-1:0] free_start,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic      [PAGE_W-1:0] start_page,
    output logic      [LEN_W-1:0]  pages_free
);

    localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WL        = $clog2(WORD_BITS);
    localparam int PG_LOG    = $clog2(NUM_PAGES);
    localparam int PW        = (PG_LOG > 14) ? PG_LOG + 1 : 15;
    localparam int HW        = WL + 1;
    localparam int CNT_CAP   = (NUM_PAGES < COUNTER_MAX) ? NUM_PAGES : COUNTER_MAX;
    localparam int PROD_W    = 2 * LEN_W + 1;

    localparam logic [PW-1:0]    NUM_P   = PW'(NUM_PAGES);
    localparam logic [LEN_W:0]   CAP_V   = (LEN_W + 1)'(CNT_CAP);
    localparam logic [HW-1:0]    FULL_HI = HW'(WORD_BITS);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_CHK,
        S_RD,
        S_EVAL,
        S_DIV,
        S_DWAIT,
        S_MUL,
        S_ADV,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [PAGE_W-1:0] base_reg;
    logic [LEN_W-1:0]  top_reg;

    logic              free_op_reg;
    logic              scan_reg;
    logic              set_reg;
    logic [PW-1:0]     idx_reg;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     end_reg;
    logic [PW-1:0]     lim_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  step_reg;
    logic [PW-1:0]     hit_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic              res_found_reg;
    logic [PAGE_W-1:0] res_start_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [PAGE_W-1:0] out_start_reg;
    logic [LEN_W-1:0]  out_free_reg;

    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;
    logic                 rd_en;
    logic                 map_ready;
    logic [AW-1:0]        word_addr;
    logic                 out_load;

    div_ctl_t          div_ctl;
    logic [LEN_W-1:0]  div_quo;
    logic [LEN_W-1:0]  div_num;

    logic [PW-1:0]        lim_top;
    logic [PW-1:0]        upper_ext;
    logic [PW-1:0]        alim;
    logic [PW-1:0]        fsum;
    logic [PW-1:0]        fend;
    logic [PW-1:0]        run_end;
    logic [HW-1:0]        lo_n;
    logic [HW-1:0]        hi_n;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] hits;
    logic [WL-1:0]        hit_bit;
    logic [PW-1:0]        next_pos;
    logic [LEN_W:0]       cnt_sum;
    logic [LEN_W-1:0]     cnt_new;

    function automatic logic [WORD_BITS-1:0] low_ones(input logic [HW-1:0] n);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = (HW'(i) < n);
        end
        return m;
    endfunction

    bpa_map #(
        .WORDS (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (word_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (word_addr),
        .wr_data (wr_data),
        .ready   (map_ready)
    );

    bpa_div #(
        .W (LEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV),
        .num   (div_num),
        .den   (step_reg),
        .ctl   (div_ctl),
        .quo   (div_quo)
    );

    assign div_num = LEN_W'(hit_reg - idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            top_reg  <= LEN_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE_PAGE: base_reg <= cfg_data[PAGE_W-1:0];
                CFG_TOP_PAGE:  top_reg  <= cfg_data[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    assign lim_top   = (PW'(top_reg) < NUM_P) ? PW'(top_reg) : NUM_P;
    assign upper_ext = PW'(upper_page);
    assign alim      = (upper_page != '0 && upper_ext < lim_top) ? upper_ext : lim_top;
    assign fsum      = PW'(free_start) + PW'(run_length);
    assign fend      = (fsum < lim_top) ? fsum : lim_top;
    assign run_end   = idx_reg + PW'(len_reg);

    assign word_addr = pos_reg[WL+AW-1:WL];
    assign lo_n      = {1'b0, pos_reg[WL-1:0]};
    assign hi_n      = (end_reg[PW-1:WL] == pos_reg[PW-1:WL])
                       ? {1'b0, end_reg[WL-1:0]} : FULL_HI;
    assign mask      = low_ones(hi_n) & ~low_ones(lo_n);
    assign hits      = rd_data & mask;
    assign next_pos  = {pos_reg[PW-1:WL] + 1'b1, {WL{1'b0}}};
    assign wr_data   = set_reg ? (rd_data | mask) : (rd_data & ~mask);
    assign wr_en     = (state_reg == S_EVAL) && !scan_reg;
    assign rd_en     = (state_reg == S_RD);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (hits[i])
                hit_bit = WL'(i);
        end
    end

    assign cnt_sum = free_op_reg ? ({1'b0, cnt_reg} + {1'b0, len_reg})
                                 : ({1'b0, cnt_reg} - {1'b0, len_reg});
    always_comb
    begin
        if (free_op_reg)
            cnt_new = (cnt_sum > CAP_V) ? CAP_V[LEN_W-1:0] : cnt_sum[LEN_W-1:0];
        else if (!res_found_reg)
            cnt_new = cnt_reg;
        else
            cnt_new = (cnt_reg > len_reg) ? cnt_sum[LEN_W-1:0] : '0;
    end

    assign in_ready = (state_reg == S_IDLE) && map_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (func_t'(func) == FUNC_FREE)
                            state_reg <= (free_start < fend[PAGE_W:0] || PW'(free_start) < fend)
                                         ? S_RD : S_DONE;
                        else
                            state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (idx_reg < lim_reg && run_end <= lim_reg)
                        state_reg <= (len_reg == '0) ? S_DONE : S_RD;
                    else
                        state_reg <= S_DONE;
                end
                S_RD:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (scan_reg && hits != '0)
                        state_reg <= S_DIV;
                    else if (next_pos >= end_reg && !scan_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RD;
                end
                S_DIV:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_ctl.done)
                        state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_ADV;
                S_ADV:
                    state_reg <= S_CHK;
                S_DONE:
                begin
                    if (out_load)
                    begin
                        cnt_reg   <= cnt_new;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                free_op_reg   <= (func_t'(func) == FUNC_FREE);
                len_reg       <= run_length;
                step_reg      <= (align_step == '0) ? LEN_W'(1) : align_step;
                idx_reg       <= PW'(base_reg);
                lim_reg       <= alim;
                pos_reg       <= PW'(free_start);
                end_reg       <= fend;
                scan_reg      <= (func_t'(func) != FUNC_FREE);
                set_reg       <= 1'b0;
                res_found_reg <= (func_t'(func) == FUNC_FREE);
                res_start_reg <= '0;
            end
            S_CHK:
            begin
                pos_reg <= idx_reg;
                end_reg <= run_end;
                if (idx_reg < lim_reg && run_end <= lim_reg && len_reg == '0)
                begin
                    res_found_reg <= 1'b1;
                    res_start_reg <= idx_reg[PAGE_W-1:0];
                end
            end
            S_EVAL:
            begin
                if (scan_reg && hits != '0)
                    hit_reg <= {pos_reg[PW-1:WL], hit_bit};
                else if (scan_reg && next_pos >= end_reg)
                begin
                    scan_reg      <= 1'b0;
                    set_reg       <= 1'b1;
                    pos_reg       <= idx_reg;
                    res_found_reg <= 1'b1;
                    res_start_reg <= idx_reg[PAGE_W-1:0];
                end
                else
                    pos_reg <= next_pos;
            end
            S_MUL:
                prod_reg <= PROD_W'(({1'b0, div_quo} + 1'b1) * step_reg);
            S_ADV:
                idx_reg <= idx_reg + prod_reg[PW-1:0];
            S_DONE:
            begin
                if (out_load)
                begin
                    out_found_reg <= res_found_reg;
                    out_start_reg <= res_start_reg;
                    out_free_reg  <= cnt_new;
                end
            end
            default:
                ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign start_page = out_start_reg;
    assign pages_free = out_free_reg;

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, pages_free} <= CAP_V))
        else $error("free counter above cap");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> start_page == '0)
        else $error("start page set without a fit");

    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !in_ready)
        else $error("bitmap write while idle");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait");

endmodule
`default_nettype wire
